### design/windowed_pid_steering_assert.svh
// assertion macros shared by the windowed pid steering rtl
// depends on nothing; included by files that check their own logic
`ifndef WINDOWED_PID_STEERING_ASSERT_SVH
`define WINDOWED_PID_STEERING_ASSERT_SVH

// same-cycle implication, muted while reset is high
`define WPS_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");

// next-cycle implication, muted while reset is high
`define WPS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

### design/wps_pkg.sv
`timescale 1ns / 1ps
// types and fixed constants of the windowed pid steering block
// depends on nothing; used by the channel interfaces and the top level
package wps_pkg;

   // field widths
   localparam int ERR_W      = 16;
   localparam int GAIN_W     = 24;
   localparam int WLEN_W     = 7;
   localparam int STEER_W    = 16;
   localparam int THROTTLE_W = 14;
   localparam int TOTAL_W    = 48;
   localparam int SQ_W       = 32;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   // fixed point: +1.0 in q.28, half an output lsb, q1.14 offset
   localparam longint STEER_ONE_Q28 = 64'sd268435456;
   localparam longint STEER_HALF_LSB = 64'sd8192;
   localparam logic [STEER_W-1:0] STEER_OFFSET = 16'd16384;
   localparam logic signed [STEER_W-1:0] STEER_MAX = 16'sd16384;
   localparam logic signed [STEER_W-1:0] STEER_MIN = -16'sd16384;

   // throttle thresholds on steer (0.1, 0.07, 0.03) and levels
   localparam logic signed [STEER_W-1:0] THR_EDGE_HI  = 16'sd1638;
   localparam logic signed [STEER_W-1:0] THR_EDGE_MID = 16'sd1147;
   localparam logic signed [STEER_W-1:0] THR_EDGE_LO  = 16'sd492;
   localparam logic [THROTTLE_W-1:0] THR_LEVEL_NONE  = 14'd0;
   localparam logic [THROTTLE_W-1:0] THR_LEVEL_TENTH = 14'd1638;
   localparam logic [THROTTLE_W-1:0] THR_LEVEL_30PCT = 14'd4915;
   localparam logic [THROTTLE_W-1:0] THR_LEVEL_HALF  = 14'd8192;

   // register index, taken from paddr[3:2]
   typedef enum logic [1:0] {
      REG_PROP_GAIN     = 2'd0,
      REG_INTEG_GAIN    = 2'd1,
      REG_DERIV_GAIN    = 2'd2,
      REG_WINDOW_LENGTH = 2'd3
   } csr_index_type;

   // window trim sequencer
   typedef enum logic [1:0] {
      TRIM_IDLE = 2'b01,
      TRIM_SUB  = 2'b10
   } trim_state_type;

endpackage

### design/wps_req_if.sv
`timescale 1ns / 1ps
// input channel: one cross-track error sample per beat
// depends on wps_pkg
interface wps_req_if
   import wps_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic signed [ERR_W-1:0] cross_track_error;

   modport source (output valid, output cross_track_error, input ready);
   modport sink   (input valid, input cross_track_error, output ready);
endinterface

### design/wps_rsp_if.sv
`timescale 1ns / 1ps
// result channel: steer, throttle and total squared error per beat
// depends on wps_pkg
interface wps_rsp_if
   import wps_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic signed [STEER_W-1:0] steer;
   logic [THROTTLE_W-1:0]     throttle;
   logic [TOTAL_W-1:0]        total_error;

   modport source (output valid, output steer, output throttle, output total_error,
                   input ready);
   modport sink   (input valid, input steer, input throttle, input total_error,
                   output ready);
endinterface

### design/windowed_pid_steering.sv
`timescale 1ns / 1ps
// windowed pid steering controller, top level
// depends on wps_pkg, wps_req_if, wps_rsp_if and windowed_pid_steering_assert.svh
//
//   channel   | direction | beat contents
//   ----------+-----------+----------------------------------------------
//   req_chan  | in        | cross_track_error (q4.12)
//   rsp_chan  | out       | steer (q1.14), throttle (q0.14), total_error
//   csr_*     | in/out    | apb: prop/integ/deriv gain, window_length
//
// one sample per cycle while results are taken and no trim runs; a result is offered once
// its beat has passed the stage-one register and the product register into the result register
// a lowered window_length is trimmed once the next beat is offered: a read and a subtract
// step per leaving sample, set by the single history read port, with input ready held low
// synchronous reset clears all controller state; history needs no clearing as the
// fill count only reaches written entries; a stalled result holds the whole pipeline
module windowed_pid_steering
   import wps_pkg::*;
#(
   parameter int WINDOW_DEPTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   wps_req_if.sink               req_chan,
   wps_rsp_if.source             rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

`include "windowed_pid_steering_assert.svh"

   localparam int PTR_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
   localparam int SUM_W  = ERR_W + FILL_W;
   localparam int DIFF_W = ERR_W + 1;
   localparam int PP_W   = GAIN_W + ERR_W;
   localparam int PD_W   = GAIN_W + DIFF_W;
   localparam int PI_W   = GAIN_W + SUM_W;
   localparam int ACC_W  = PI_W + 2;
   localparam int RND_W  = 30;

   // ring slot n places behind ptr, n in 0..WINDOW_DEPTH
   function automatic logic [PTR_W-1:0] ring_back(input logic [PTR_W-1:0] ptr,
                                                  input logic [FILL_W-1:0] n);
      int p;
      int k;
      p = int'(ptr);
      k = int'(n);
      if (p >= k) begin
         return PTR_W'(p - k);
      end else begin
         return PTR_W'(p + WINDOW_DEPTH - k);
      end
   endfunction

   // ---------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------
   logic signed [GAIN_W-1:0] prop_gain_ff, integ_gain_ff, deriv_gain_ff;
   logic [WLEN_W-1:0]        window_length_ff;
   logic                     csr_write;
   csr_index_type            csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff     <= '0;
         integ_gain_ff    <= '0;
         deriv_gain_ff    <= '0;
         window_length_ff <= WLEN_W'(64);
      end else if (csr_write) begin
         case (csr_index)
            REG_PROP_GAIN:     prop_gain_ff     <= csr_pwdata[GAIN_W-1:0];
            REG_INTEG_GAIN:    integ_gain_ff    <= csr_pwdata[GAIN_W-1:0];
            REG_DERIV_GAIN:    deriv_gain_ff    <= csr_pwdata[GAIN_W-1:0];
            REG_WINDOW_LENGTH: window_length_ff <= csr_pwdata[WLEN_W-1:0];
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      case (csr_index)
         REG_PROP_GAIN:     csr_prdata = CSR_DATA_W'(unsigned'(prop_gain_ff));
         REG_INTEG_GAIN:    csr_prdata = CSR_DATA_W'(unsigned'(integ_gain_ff));
         REG_DERIV_GAIN:    csr_prdata = CSR_DATA_W'(unsigned'(deriv_gain_ff));
         REG_WINDOW_LENGTH: csr_prdata = CSR_DATA_W'(window_length_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // effective window length, capped at the ring depth
   logic [FILL_W-1:0] win_len;
   always_comb begin
      if (int'(window_length_ff) > WINDOW_DEPTH) begin
         win_len = FILL_W'(WINDOW_DEPTH);
      end else begin
         win_len = FILL_W'(window_length_ff);
      end
   end

   // ---------------------------------------------------------------
   // pipeline control and window state
   // ---------------------------------------------------------------
   logic                     s1_valid_ff, s2_valid_ff, out_valid_ff;
   logic                     advance, accept, need_trim, trim_start;
   trim_state_type           trim_state_ff, trim_state_in;
   logic [PTR_W-1:0]         ptr_ff, ptr_in, rd_addr;
   logic [FILL_W-1:0]        fill_ff, fill_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic signed [ERR_W-1:0]  prev_ff;
   logic                     first_ff;
   logic [TOTAL_W-1:0]       total_ff, total_in;

   logic signed [ERR_W-1:0]  history [WINDOW_DEPTH];
   logic signed [ERR_W-1:0]  s1_err_ff, rdata_ff;

   // trimming waits for the beat it applies to, so a window that grows back first loses nothing
   assign advance    = !out_valid_ff || rsp_chan.ready;
   assign need_trim  = fill_ff > win_len;
   assign trim_start = (trim_state_ff == TRIM_IDLE) && need_trim && !s1_valid_ff &&
                       req_chan.valid;
   assign req_chan.ready = advance && (trim_state_ff == TRIM_IDLE) && !need_trim && !reset;
   assign accept     = req_chan.valid && req_chan.ready;
   assign ptr_in     = (ptr_ff == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : ptr_ff + 1'b1;

   // read the sample leaving the window, or the oldest one while trimming
   assign rd_addr = trim_start ? ring_back(ptr_ff, fill_ff) : ring_back(ptr_ff, win_len);

   // history ring: write the new beat, registered read
   always_ff @(posedge clock) begin
      if (accept) begin
         history[ptr_ff] <= req_chan.cross_track_error;
      end
      if (accept || trim_start) begin
         rdata_ff <= history[rd_addr];
      end
      if (accept) begin
         s1_err_ff <= req_chan.cross_track_error;
      end
   end

   // window sum and fill update for the item in stage one
   logic signed [DIFF_W-1:0] diff;
   logic signed [ERR_W-1:0]  prev_use;
   logic                     s1_move;

   assign s1_move  = s1_valid_ff && advance;
   assign prev_use = first_ff ? s1_err_ff : prev_ff;
   assign diff     = DIFF_W'(s1_err_ff) - DIFF_W'(prev_use);

   always_comb begin
      sum_in        = sum_ff;
      fill_in       = fill_ff;
      trim_state_in = trim_state_ff;
      if (s1_move) begin
         if (win_len == '0) begin
            sum_in  = '0;
            fill_in = '0;
         end else if (fill_ff == win_len) begin
            sum_in  = sum_ff + SUM_W'(s1_err_ff) - SUM_W'(rdata_ff);
            fill_in = win_len;
         end else begin
            sum_in  = sum_ff + SUM_W'(s1_err_ff);
            fill_in = fill_ff + 1'b1;
         end
      end
      case (trim_state_ff)
         TRIM_IDLE: begin
            if (trim_start) begin
               trim_state_in = TRIM_SUB;
            end
         end
         TRIM_SUB: begin
            sum_in        = sum_ff - SUM_W'(rdata_ff);
            fill_in       = fill_ff - 1'b1;
            trim_state_in = TRIM_IDLE;
         end
         default: trim_state_in = TRIM_IDLE;
      endcase
   end

   // stage two: the three gain products and the square
   logic signed [PP_W-1:0] s2_pp_ff;
   logic signed [PD_W-1:0] s2_pd_ff;
   logic signed [PI_W-1:0] s2_pi_ff;
   logic [SQ_W-1:0]        s2_sq_ff;
   logic signed [SQ_W-1:0] sq_full;

   assign sq_full = SQ_W'(s1_err_ff) * SQ_W'(s1_err_ff);

   always_ff @(posedge clock) begin
      if (s1_move) begin
         s2_pp_ff <= PP_W'(prop_gain_ff) * PP_W'(s1_err_ff);
         s2_pd_ff <= PD_W'(deriv_gain_ff) * PD_W'(diff);
         s2_pi_ff <= PI_W'(integ_gain_ff) * PI_W'(sum_in);
         s2_sq_ff <= unsigned'(sq_full);
      end
   end

   // stage three: sum of terms, clamp, round, throttle, total
   logic signed [ACC_W-1:0]   acc, acc_clamp;
   logic [RND_W-1:0]          rounded;
   logic signed [STEER_W-1:0] steer_in, steer_ff;
   logic [THROTTLE_W-1:0]     throttle_in, throttle_ff;
   logic [TOTAL_W:0]          total_sum;
   logic                      s2_move;

   assign s2_move = s2_valid_ff && advance;
   assign acc = -ACC_W'(s2_pp_ff) - ACC_W'(s2_pd_ff) - ACC_W'(s2_pi_ff);

   always_comb begin
      if (acc > ACC_W'(STEER_ONE_Q28)) begin
         acc_clamp = ACC_W'(STEER_ONE_Q28);
      end else if (acc < -ACC_W'(STEER_ONE_Q28)) begin
         acc_clamp = -ACC_W'(STEER_ONE_Q28);
      end else begin
         acc_clamp = acc;
      end
   end

   // shift to [0, 2] and round half up to q1.14
   assign rounded  = RND_W'(acc_clamp + ACC_W'(STEER_ONE_Q28) + ACC_W'(STEER_HALF_LSB));
   assign steer_in = signed'(rounded[RND_W-1:14] - STEER_OFFSET);

   always_comb begin
      if (steer_in > THR_EDGE_HI) begin
         throttle_in = THR_LEVEL_NONE;
      end else if (steer_in > THR_EDGE_MID) begin
         throttle_in = THR_LEVEL_TENTH;
      end else if (steer_in > THR_EDGE_LO) begin
         throttle_in = THR_LEVEL_30PCT;
      end else begin
         throttle_in = THR_LEVEL_HALF;
      end
   end

   // saturating squared-error total
   assign total_sum = {1'b0, total_ff} + (TOTAL_W + 1)'(s2_sq_ff);
   assign total_in  = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];

   always_ff @(posedge clock) begin
      if (s2_move) begin
         steer_ff    <= steer_in;
         throttle_ff <= throttle_in;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         trim_state_ff <= TRIM_IDLE;
         ptr_ff        <= '0;
         fill_ff       <= '0;
         sum_ff        <= '0;
         prev_ff       <= '0;
         first_ff      <= 1'b1;
         total_ff      <= '0;
      end else begin
         trim_state_ff <= trim_state_in;
         fill_ff       <= fill_in;
         sum_ff        <= sum_in;
         if (accept) begin
            ptr_ff <= ptr_in;
         end
         if (advance) begin
            s1_valid_ff  <= accept;
            s2_valid_ff  <= s1_valid_ff;
            out_valid_ff <= s2_valid_ff;
         end
         if (s1_move) begin
            prev_ff  <= s1_err_ff;
            first_ff <= 1'b0;
         end
         if (s2_move) begin
            total_ff <= total_in;
         end
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.steer       = steer_ff;
   assign rsp_chan.throttle    = throttle_ff;
   assign rsp_chan.total_error = total_ff;

   // ---------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------
   `WPS_ASSERT_IMPLY(a_fill_in_window, clock, reset, s1_valid_ff, fill_ff <= win_len)
   `WPS_ASSERT_NEXT(a_trim_drops_one, clock, reset, trim_state_ff == TRIM_SUB,
      fill_ff == $past(fill_ff) - 1'b1)
   `WPS_ASSERT_IMPLY(a_steer_range, clock, reset, out_valid_ff,
      (steer_ff <= STEER_MAX) && (steer_ff >= STEER_MIN))
   `WPS_ASSERT_NEXT(a_total_grows, clock, reset, s2_move, total_ff >= $past(total_ff))

endmodule
